@@ src/add_seconds_to_calendar_date_top_defines.svh @@
// Assertion macros for the calendar date adder.
`ifndef ADD_SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH
`define ADD_SECONDS_TO_CALENDAR_DATE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/asc_pkg.sv @@
// Types, constants and the month length table for the calendar date adder.
package asc_pkg;

    localparam int YEAR_BITS       = 12;
    localparam int ADD_BITS        = 31;
    localparam int DIV_BITS        = 32;
    localparam int OPND_BITS       = DIV_BITS - 2;
    localparam int RCP_BITS        = 31;
    localparam int PROD_BITS       = OPND_BITS + RCP_BITS;
    localparam int REM_BITS        = 6;
    localparam int DAY_BITS        = 16;
    localparam int SEC_PER_MIN     = 60;
    localparam int MIN_PER_HOUR    = 60;
    localparam int HOUR_PER_DAY    = 24;
    localparam int MONTHS_PER_YEAR = 12;

    // floor(x/60) = (floor(x/4) * RCP_MIN) >> 34, floor(x/24) = (floor(x/8) * RCP_DAY) >> 32
    localparam int                  RCP_SHIFT_MIN = 34;
    localparam int                  RCP_SHIFT_DAY = 32;
    localparam logic [RCP_BITS-1:0] RCP_MIN       = 31'h4444_4445;
    localparam logic [RCP_BITS-1:0] RCP_DAY       = 31'h5555_5556;

    typedef struct packed {
        logic [5:0]           in_second;
        logic [5:0]           in_minute;
        logic [4:0]           in_hour;
        logic [4:0]           in_day;
        logic [3:0]           in_month;
        logic [YEAR_BITS-1:0] in_year;
        logic [ADD_BITS-1:0]  add_seconds;
    } asc_in_t;

    typedef struct packed {
        logic [5:0]           out_second;
        logic [5:0]           out_minute;
        logic [4:0]           out_hour;
        logic [4:0]           out_day;
        logic [3:0]           out_month;
        logic [YEAR_BITS-1:0] out_year;
    } asc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_WALK,
        ST_DONE
    } asc_state_t;

    typedef enum logic [1:0] {
        STG_SEC,
        STG_MIN,
        STG_HOUR
    } asc_stage_t;

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        case (mon) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

@@ src/add_seconds_to_calendar_date_top.sv @@
// Three divide steps (seconds, minutes, hours), each a multiply state then a remainder state,
// then the month walk, then the result is held in the done state until it is accepted.
// One shared reciprocal multiplier divides by 60 or 24; the walk takes one month a cycle.
// A new word is accepted only in idle, once the result of the last word has been accepted.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops any word in flight.
// Top level of the calendar date adder: sequencer, shared divider and month walk.
`include "add_seconds_to_calendar_date_top_defines.svh"

module add_seconds_to_calendar_date_top
    import asc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  asc_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output asc_out_t rsp
);

    asc_state_t           state_reg, state_next;
    asc_stage_t           stage_reg, stage_next;
    logic [DIV_BITS-1:0]  num_reg, num_next;
    logic [DIV_BITS-1:0]  quo_reg, quo_next;
    asc_in_t              hold_reg, hold_next;
    logic [DAY_BITS-1:0]  day_reg, day_next;
    logic [3:0]           mon_reg, mon_next;
    logic [YEAR_BITS-1:0] year_reg, year_next;
    asc_out_t             res_reg, res_next;

    logic [OPND_BITS-1:0] opnd;
    logic [RCP_BITS-1:0]  rcp;
    logic [PROD_BITS-1:0] prod;
    logic [DIV_BITS-1:0]  quo_calc;
    logic [DIV_BITS-1:0]  quo_scaled;
    logic [DIV_BITS-1:0]  rem_full;
    logic [REM_BITS-1:0]  rem_step;
    logic [4:0]           len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stage_reg <= STG_SEC;
        end
        else
        begin
            state_reg <= state_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        hold_reg <= hold_next;
        day_reg  <= day_next;
        mon_reg  <= mon_next;
        year_reg <= year_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        if (stage_reg == STG_HOUR)
        begin
            opnd = {1'b0, num_reg[DIV_BITS-1:3]};
            rcp  = RCP_DAY;
        end
        else
        begin
            opnd = num_reg[DIV_BITS-1:2];
            rcp  = RCP_MIN;
        end
        prod = PROD_BITS'(opnd) * PROD_BITS'(rcp);
        if (stage_reg == STG_HOUR)
        begin
            quo_calc   = DIV_BITS'(prod[PROD_BITS-1:RCP_SHIFT_DAY]);
            quo_scaled = quo_reg * DIV_BITS'(HOUR_PER_DAY);
        end
        else
        begin
            quo_calc   = DIV_BITS'(prod[PROD_BITS-1:RCP_SHIFT_MIN]);
            quo_scaled = quo_reg * DIV_BITS'(SEC_PER_MIN);
        end
        rem_full = num_reg - quo_scaled;
        rem_step = rem_full[REM_BITS-1:0];
        len      = month_len(year_reg[1:0] == 2'd0, mon_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        hold_next  = hold_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        res_next   = res_reg;
        req_stall  = (state_reg != ST_IDLE);
        rsp_valid  = (state_reg == ST_DONE);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    hold_next  = req;
                    num_next   = DIV_BITS'(req.add_seconds) + DIV_BITS'(req.in_second);
                    stage_next = STG_SEC;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                quo_next   = quo_calc;
                state_next = ST_REM;
            end
            ST_REM:
            begin
                state_next = ST_MUL;
                case (stage_reg)
                    STG_SEC:
                    begin
                        res_next.out_second = rem_step;
                        num_next   = DIV_BITS'(hold_reg.in_minute) + quo_reg;
                        stage_next = STG_MIN;
                    end
                    STG_MIN:
                    begin
                        res_next.out_minute = rem_step;
                        num_next   = DIV_BITS'(hold_reg.in_hour) + quo_reg;
                        stage_next = STG_HOUR;
                    end
                    STG_HOUR:
                    begin
                        res_next.out_hour = rem_step[4:0];
                        day_next   = DAY_BITS'(hold_reg.in_day) + quo_reg[DAY_BITS-1:0];
                        mon_next   = hold_reg.in_month;
                        year_next  = hold_reg.in_year;
                        stage_next = STG_SEC;
                        state_next = ST_WALK;
                    end
                    default:
                    begin
                        stage_next = STG_SEC;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (day_reg > DAY_BITS'(len))
                begin
                    day_next = day_reg - DAY_BITS'(len);
                    if (mon_reg >= 4'(MONTHS_PER_YEAR))
                    begin
                        mon_next  = 4'd1;
                        year_next = year_reg + 1'b1;
                    end
                    else
                    begin
                        mon_next = mon_reg + 1'b1;
                    end
                end
                else
                begin
                    res_next.out_day   = day_reg[4:0];
                    res_next.out_month = mon_reg;
                    res_next.out_year  = year_reg;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp = res_reg;

    `ASC_ASSERT_NEXT(a_accept_starts_div, req_valid && !req_stall,
        state_reg == ST_MUL && stage_reg == STG_SEC,
        "accepted word did not start the seconds division")
    `ASC_ASSERT_NOW(a_time_in_range, rsp_valid,
        rsp.out_second < 6'd60 && rsp.out_minute < 6'd60 && rsp.out_hour < 5'd24,
        "time field of result out of range")
    `ASC_ASSERT_NOW(a_busy_while_result, rsp_valid || state_reg == ST_WALK,
        req_stall, "request taken while a word is in flight")

endmodule

@@ tb/tb_add_seconds_to_calendar_date_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the calendar date adder: corner dates, random dates, noise words.
module tb_add_seconds_to_calendar_date_top
    import asc_pkg::*;
();

    localparam int STUCK_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1000;
    localparam int unsigned MAX_ADD   = (32'd1 << ADD_BITS) - 32'd1;
    localparam int unsigned LAST_YEAR = (32'd1 << YEAR_BITS) - 32'd1;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    asc_in_t  req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    asc_out_t rsp;

    int unsigned days_in_month [16] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0};

    asc_out_t pending_dates [$];
    asc_out_t want_date;
    int       mismatches   = 0;
    int       stuck_cycles = 0;
    bit       no_idle      = 1'b0;

    add_seconds_to_calendar_date_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
        if (mon == 2 && (yr % 4) == 0)
            return 29;
        return days_in_month[mon % 16];
    endfunction

    function automatic asc_out_t advance_date(input asc_in_t w);
        longint unsigned secs;
        longint unsigned mins;
        longint unsigned hours;
        int unsigned     day;
        int unsigned     mon;
        int unsigned     yr;
        asc_out_t        r;
        secs  = 64'(w.in_second);
        secs  = secs + 64'(w.add_seconds);
        mins  = 64'(w.in_minute);
        mins  = mins + secs / 60;
        hours = 64'(w.in_hour);
        hours = hours + mins / 60;
        day   = 32'(w.in_day);
        day   = day + 32'(hours / 24);
        mon   = 32'(w.in_month);
        yr    = 32'(w.in_year);
        while (day > month_length(yr, mon))
        begin
            day = day - month_length(yr, mon);
            mon = mon + 1;
            if (mon >= 13)
            begin
                mon = 1;
                yr  = (yr + 1) % (1 << YEAR_BITS);
            end
        end
        r.out_second = 6'(secs % 60);
        r.out_minute = 6'(mins % 60);
        r.out_hour   = 5'(hours % 24);
        r.out_day    = day[4:0];
        r.out_month  = mon[3:0];
        r.out_year   = yr[YEAR_BITS-1:0];
        return r;
    endfunction

    function automatic logic [ADD_BITS-1:0] pick_addend();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return ADD_BITS'($urandom_range(0, 3600));
        if (sel < 55)
            return ADD_BITS'($urandom_range(0, 86400 * 3));
        if (sel < 82)
            return ADD_BITS'($urandom_range(0, 86400 * 400));
        if (sel < 93)
            return ADD_BITS'($urandom_range(0, 86400 * 3000));
        return ADD_BITS'($urandom_range(0, MAX_ADD));
    endfunction

    function automatic asc_in_t random_date();
        asc_in_t     w;
        int unsigned len;
        w.in_second   = 6'($urandom_range(0, 59));
        w.in_minute   = 6'($urandom_range(0, 59));
        w.in_hour     = 5'($urandom_range(0, 23));
        w.in_month    = 4'($urandom_range(1, 12));
        w.in_year     = YEAR_BITS'($urandom_range(0, LAST_YEAR));
        len           = month_length(32'(w.in_year), 32'(w.in_month));
        w.in_day      = 5'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
        w.add_seconds = pick_addend();
        return w;
    endfunction

    function automatic asc_in_t make_word(input int unsigned s, input int unsigned m,
                                          input int unsigned h, input int unsigned d,
                                          input int unsigned mo, input int unsigned y,
                                          input int unsigned add);
        asc_in_t w;
        w.in_second   = 6'(s);
        w.in_minute   = 6'(m);
        w.in_hour     = 5'(h);
        w.in_day      = 5'(d);
        w.in_month    = 4'(mo);
        w.in_year     = YEAR_BITS'(y);
        w.add_seconds = ADD_BITS'(add);
        return w;
    endfunction

    task automatic send_word(input asc_in_t w);
        int gap;
        gap = 0;
        if (!no_idle)
            while ($urandom_range(0, 99) < 25)
                gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_dates.push_back(advance_date(w));
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic test_directed_corners();
        send_word(make_word(0, 0, 0, 1, 1, 0, 0));
        send_word(make_word(59, 59, 23, 31, 12, LAST_YEAR, 1));
        send_word(make_word(59, 59, 23, 31, 1, 2024, 1));
        send_word(make_word(0, 0, 0, 28, 2, 2024, 86400));
        send_word(make_word(0, 0, 0, 28, 2, 2023, 86400));
        send_word(make_word(0, 0, 0, 29, 2, 2024, 86400));
        send_word(make_word(0, 0, 0, 1, 1, 2001, MAX_ADD));
        send_word(make_word(59, 59, 23, 31, 12, LAST_YEAR, MAX_ADD));
        send_word(make_word(63, 63, 31, 31, 15, LAST_YEAR, MAX_ADD));
        send_word(make_word(63, 63, 31, 0, 0, 0, 0));
        send_word(make_word(0, 0, 0, 0, 5, 100, 0));
        send_word(make_word(0, 0, 0, 0, 5, 100, 3600));
        send_word(make_word(0, 0, 0, 0, 5, 100, 86400));
        send_word(make_word(0, 0, 0, 10, 0, 100, 60));
        send_word(make_word(0, 0, 0, 10, 13, 100, 0));
        send_word(make_word(0, 0, 0, 10, 14, 100, 0));
        send_word(make_word(0, 0, 0, 10, 15, 100, 0));
        send_word(make_word(0, 0, 0, 31, 15, LAST_YEAR, 0));
        send_word(make_word(30, 30, 12, 15, 6, 2000, 59));
        send_word(make_word(0, 59, 23, 30, 4, 2000, 60));
        send_word(make_word(0, 0, 0, 1, 3, 0, 86400 * 365));
        send_word(make_word(59, 59, 23, 31, 12, LAST_YEAR, 0));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) send_word(random_date());
    endtask

    task automatic test_unbroken_burst(input int count);
        no_idle = 1'b1;
        repeat (count) send_word(random_date());
        no_idle = 1'b0;
    endtask

    task automatic test_noise_fields(input int count);
        asc_in_t     w;
        logic [95:0] noise;
        repeat (count)
        begin
            noise = {$urandom, $urandom, $urandom};
            w     = noise[$bits(asc_in_t)-1:0];
            if ($urandom_range(0, 3) != 0)
                w.add_seconds = pick_addend();
            send_word(w);
        end
    endtask

    always @(posedge clk)
        rsp_stall <= !no_idle && ($urandom_range(0, 99) < 25);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t unexpected word: expected none actual %p", $time, rsp);
                mismatches++;
            end
            else
            begin
                want_date = pending_dates.pop_front();
                check_field("out_second", want_date.out_second, rsp.out_second);
                check_field("out_minute", want_date.out_minute, rsp.out_minute);
                check_field("out_hour", want_date.out_hour, rsp.out_hour);
                check_field("out_day", want_date.out_day, rsp.out_day);
                check_field("out_month", want_date.out_month, rsp.out_month);
                check_field("out_year", want_date.out_year, rsp.out_year);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_dates(400);
        test_unbroken_burst(100);
        test_noise_fields(140);
        req_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
